>>> hw/rtl/ghp_pkg.sv
// Shared constants and types for the generational handle pool.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ghp_pkg;

  // Default configuration
  localparam int unsigned NUM_SLOTS_DEF    = 256;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned IDXF_W   = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned DATA_W   = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Operation codes
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [1:0] FUNC_RETAIN  = 2'd2;
  localparam logic [1:0] FUNC_RELEASE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // How an operation gets its slot: read from memory, fresh slot, pool full,
  // or index beyond the high-water mark
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_FRESH = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [DATA_W-1:0]   payload_out;
    logic [COUNT_W-1:0]  count_out;
    logic                freed;
  } result_t;

  // Write-back commands from the execute unit
  typedef struct packed {
    logic slot_we;
    logic push;
  } wb_t;

endpackage

>>> hw/rtl/ghp_if.sv
// Valid/ready channel interfaces for the handle pool request and result paths.
// Depends on ghp_pkg for field widths.
`timescale 1ns / 1ps

interface ghp_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [ghp_pkg::HANDLE_W-1:0]  handle;
  logic [ghp_pkg::DATA_W-1:0]    payload;

  modport source (output valid, func, handle, payload, input ready);
  modport sink   (input valid, func, handle, payload, output ready);
endinterface

interface ghp_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ghp_pkg::HANDLE_W-1:0]  handle_out;
  logic [ghp_pkg::DATA_W-1:0]    payload_out;
  logic [ghp_pkg::COUNT_W-1:0]   count_out;
  logic                          freed;

  modport source (output valid, status, handle_out, payload_out, count_out, freed,
                  input ready);
  modport sink   (input valid, status, handle_out, payload_out, count_out, freed,
                  output ready);
endinterface

>>> hw/rtl/ghp_exec.sv
// Execute unit: turns one slot entry read plus the request into the result
// and the modified entry. Depends on ghp_pkg.
`timescale 1ns / 1ps

module ghp_exec #(
  parameter int unsigned IDX_W        = 8,
  parameter int unsigned PAYLOAD_BITS = ghp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic [1:0]                    func,
  input  logic [1:0]                    kind,
  input  logic [ghp_pkg::HANDLE_W-1:0]  handle,
  input  logic [ghp_pkg::DATA_W-1:0]    pay_in,
  input  logic [IDX_W-1:0]              idx,
  input  logic [ghp_pkg::GEN_W-1:0]     rd_gen,
  input  logic [ghp_pkg::COUNT_W-1:0]   rd_cnt,
  input  logic                          rd_free,
  input  logic [PAYLOAD_BITS-1:0]       rd_pay,
  output ghp_pkg::result_t              res,
  output ghp_pkg::wb_t                  wb,
  output logic [ghp_pkg::GEN_W-1:0]     wr_gen,
  output logic [ghp_pkg::COUNT_W-1:0]   wr_cnt,
  output logic                          wr_free,
  output logic [PAYLOAD_BITS-1:0]       wr_pay
);
  import ghp_pkg::*;

  logic [PAYLOAD_BITS-1:0] pay_w;
  logic [DATA_W-1:0]       pay_rd;
  logic                    live;
  logic [GEN_W-1:0]        gen_inc;
  logic [GEN_W-1:0]        gen_new;
  logic [GEN_W-1:0]        gen_use;
  logic [COUNT_W-1:0]      cnt_dec;

  // Stored payload keeps the low PAYLOAD_BITS bits of the request word
  genvar b;
  for (b = 0; b < PAYLOAD_BITS; b++) begin : g_wpay
    if (b < DATA_W) begin : g_bit
      assign pay_w[b] = pay_in[b];
    end else begin : g_zero
      assign pay_w[b] = 1'b0;
    end
  end
  for (b = 0; b < DATA_W; b++) begin : g_rpay
    if (b < PAYLOAD_BITS) begin : g_bit
      assign pay_rd[b] = rd_pay[b];
    end else begin : g_zero
      assign pay_rd[b] = 1'b0;
    end
  end

  // Generation bump wraps past zero to one; stored generations are never zero
  assign gen_inc = rd_gen + 1'b1;
  assign gen_new = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign gen_use = (kind == KIND_READ) ? gen_new : GEN_W'(1);
  assign cnt_dec = (rd_cnt != '0) ? rd_cnt - 1'b1 : '0;
  assign live    = !rd_free && (rd_gen == handle[HANDLE_W-1 -: GEN_W]);

  always_comb begin
    res     = '0;
    wb      = '0;
    wr_gen  = rd_gen;
    wr_cnt  = rd_cnt;
    wr_free = rd_free;
    wr_pay  = rd_pay;
    if (func == FUNC_ALLOC) begin
      if (kind == KIND_FULL) begin
        res.status = ST_FULL;
      end else begin
        wb.slot_we     = 1'b1;
        wr_gen         = gen_use;
        wr_cnt         = COUNT_W'(1);
        wr_free        = 1'b0;
        wr_pay         = pay_w;
        res.status     = ST_OK;
        res.handle_out = {gen_use, IDXF_W'(idx)};
        res.count_out  = COUNT_W'(1);
      end
    end else if (kind != KIND_READ || !live) begin
      res.status = ST_INVALID;
    end else begin
      unique case (func)
        FUNC_LOOKUP: begin
          res.status      = ST_OK;
          res.payload_out = pay_rd;
          res.count_out   = rd_cnt;
        end
        FUNC_RETAIN: begin
          if (rd_cnt == COUNT_MAX) begin
            res.status    = ST_SATURATED;
            res.count_out = COUNT_MAX;
          end else begin
            wb.slot_we    = 1'b1;
            wr_cnt        = rd_cnt + 1'b1;
            res.status    = ST_OK;
            res.count_out = rd_cnt + 1'b1;
          end
        end
        FUNC_RELEASE: begin
          wb.slot_we = 1'b1;
          wr_cnt     = cnt_dec;
          res.status = ST_OK;
          if (cnt_dec == '0) begin
            wr_free   = 1'b1;
            wb.push   = 1'b1;
            res.freed = 1'b1;
          end else begin
            res.count_out = cnt_dec;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/generational_handle_pool.sv
// Generational handle pool: top level with slot memory, free-stack memory
// and the request sequencer. Depends on ghp_pkg, ghp_if and ghp_exec.
//
// Usage: requests arrive on in_ch (func, handle, payload); one result per
// request leaves on out_ch (status, handle_out, payload_out, count_out, freed),
// in request order. A transfer happens when valid and ready are both high.
// Handles carry the generation in bits 31..16 and the slot index below it.
// Lookup, retain, release, fresh allocate and pool-full are registered into
// the request context, then the result into the output register once it is
// free; allocate that reuses a freed slot first does the free-stack read.
// A new request is taken only after the last has left execute: each item
// does one read-modify-write of the slot memory, read then write back.
// Reset empties the pool (free-stack top and high-water mark to zero); the
// memories are not cleared, only slots below the high-water mark are read.
// A result stalled by the receiver sits in the output register; the next
// request is still taken and waits in execute until the register drains.
`timescale 1ns / 1ps

module generational_handle_pool #(
  parameter int unsigned NUM_SLOTS    = ghp_pkg::NUM_SLOTS_DEF,
  parameter int unsigned PAYLOAD_BITS = ghp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ghp_in_if.sink     in_ch,
  ghp_out_if.source  out_ch
);
  import ghp_pkg::*;

  localparam int unsigned IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned ENT_W  = GEN_W + COUNT_W + 1 + PAYLOAD_BITS;
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(NUM_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // Control state
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] free_top_r, free_top_nxt;
  logic [CNT_W-1:0] high_water_r, high_water_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Request context
  logic [1:0]          func_r, func_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [HANDLE_W-1:0] hdl_r, hdl_nxt;
  logic [DATA_W-1:0]   pay_r, pay_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  result_t             res_r;

  // Memories
  logic [ENT_W-1:0] slot_mem [NUM_SLOTS];
  logic [IDX_W-1:0] stack_mem [NUM_SLOTS];
  logic [ENT_W-1:0] slot_rd_r;
  logic [IDX_W-1:0] stack_rd_r;

  logic             in_fire, out_free, exec_fire;
  logic [IDXF_W-1:0] hidx;
  logic             in_range;
  logic [CNT_W-1:0] ft_dec;
  logic             slot_re, stack_re, stack_we, slot_we;
  logic [IDX_W-1:0] slot_raddr;
  logic [ENT_W-1:0] slot_wdata;

  result_t                 res;
  wb_t                     wb;
  logic [GEN_W-1:0]        wr_gen;
  logic [COUNT_W-1:0]      wr_cnt;
  logic                    wr_free;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign exec_fire   = (state_r == S_EXEC) && out_free;
  assign hidx        = in_ch.handle[IDXF_W-1:0];
  assign in_range    = (17'(hidx) < 17'(high_water_r));
  assign ft_dec      = free_top_r - 1'b1;

  // Read-modify-write of the slot entry
  ghp_exec #(
    .IDX_W        (IDX_W),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_exec (
    .func    (func_r),
    .kind    (kind_r),
    .handle  (hdl_r),
    .pay_in  (pay_r),
    .idx     (idx_r),
    .rd_gen  (slot_rd_r[ENT_W-1 -: GEN_W]),
    .rd_cnt  (slot_rd_r[ENT_W-GEN_W-1 -: COUNT_W]),
    .rd_free (slot_rd_r[PAYLOAD_BITS]),
    .rd_pay  (slot_rd_r[PAYLOAD_BITS-1:0]),
    .res     (res),
    .wb      (wb),
    .wr_gen  (wr_gen),
    .wr_cnt  (wr_cnt),
    .wr_free (wr_free),
    .wr_pay  (wr_pay)
  );

  assign slot_wdata = {wr_gen, wr_cnt, wr_free, wr_pay};
  assign slot_we    = exec_fire && wb.slot_we;
  assign stack_we   = exec_fire && wb.push && (free_top_r < DEPTH);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    free_top_nxt   = free_top_r;
    high_water_nxt = high_water_r;
    func_nxt       = func_r;
    kind_nxt       = kind_r;
    hdl_nxt        = hdl_r;
    pay_nxt        = pay_r;
    idx_nxt        = idx_r;
    slot_re        = 1'b0;
    slot_raddr     = hidx[IDX_W-1:0];
    stack_re       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt = in_ch.func;
          hdl_nxt  = in_ch.handle;
          pay_nxt  = in_ch.payload;
          idx_nxt  = hidx[IDX_W-1:0];
          if (in_ch.func == FUNC_ALLOC) begin
            if (free_top_r != '0) begin
              // reuse the most recently freed slot
              kind_nxt     = KIND_READ;
              stack_re     = 1'b1;
              free_top_nxt = ft_dec;
              state_nxt    = S_POP;
            end else if (high_water_r < DEPTH) begin
              kind_nxt       = KIND_FRESH;
              idx_nxt        = high_water_r[IDX_W-1:0];
              high_water_nxt = high_water_r + 1'b1;
              state_nxt      = S_EXEC;
            end else begin
              kind_nxt  = KIND_FULL;
              state_nxt = S_EXEC;
            end
          end else begin
            kind_nxt  = in_range ? KIND_READ : KIND_BAD;
            slot_re   = in_range;
            state_nxt = S_EXEC;
          end
        end
      end
      S_POP: begin
        idx_nxt    = stack_rd_r;
        slot_raddr = stack_rd_r;
        slot_re    = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
          if (stack_we) begin
            free_top_nxt = free_top_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: loads on execute, drains on an output transfer
  always_comb begin
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_top_r   <= '0;
      high_water_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_top_r   <= free_top_nxt;
      high_water_r <= high_water_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    kind_r <= kind_nxt;
    hdl_r  <= hdl_nxt;
    pay_r  <= pay_nxt;
    idx_r  <= idx_nxt;
    if (exec_fire) begin
      res_r <= res;
    end
  end

  // Slot memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[idx_r] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_r <= slot_mem[slot_raddr];
    end
  end

  // Free-stack memory
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[free_top_r[IDX_W-1:0]] <= idx_r;
    end
    if (stack_re) begin
      stack_rd_r <= stack_mem[ft_dec[IDX_W-1:0]];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.handle_out  = res_r.handle_out;
  assign out_ch.payload_out = res_r.payload_out;
  assign out_ch.count_out   = res_r.count_out;
  assign out_ch.freed       = res_r.freed;

endmodule

>>> hw/rtl/ghp_checker.sv
// Port-level assertions for the generational handle pool, bound to the top.
// Depends on ghp_pkg and generational_handle_pool.
`timescale 1ns / 1ps

module ghp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [ghp_pkg::HANDLE_W-1:0]  out_handle,
  input logic [ghp_pkg::DATA_W-1:0]    out_payload,
  input logic [ghp_pkg::COUNT_W-1:0]   out_count,
  input logic                          out_freed
);
  import ghp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_handle) && $stable(out_payload) && $stable(out_count))
    else $error("stalled result changed");

  // One request at a time: after a transfer the input side closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // A handed-out handle carries a nonzero generation and a fresh count
  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_handle != '0 |-> out_status == ST_OK &&
      out_handle[HANDLE_W-1 -: GEN_W] != '0 && out_count == COUNT_W'(1) &&
      out_payload == '0 && !out_freed)
    else $error("bad allocate result");

  // Freeing reports a zero count; full and invalid results report nothing else
  a_freed_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_freed || out_status == ST_FULL || out_status == ST_INVALID) |->
      out_count == '0 && out_payload == '0 && out_handle == '0 &&
      (out_freed ? out_status == ST_OK : 1'b1))
    else $error("inconsistent freed or failure result");

endmodule

bind generational_handle_pool ghp_checker u_ghp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_handle  (out_ch.handle_out),
  .out_payload (out_ch.payload_out),
  .out_count   (out_ch.count_out),
  .out_freed   (out_ch.freed)
);
